// ===== rtl/sbst_pkg.sv =====
`timescale 1ns / 1ps

package sbst_pkg;

    localparam int MAX_V     = 64;
    localparam int V_BITS    = 6;
    localparam int CNT_BITS  = 7;
    localparam int W_BITS    = 20;
    localparam int EDGE_CAP  = 2016;
    localparam int E_BITS    = 11;
    localparam int FILL_BITS = 12;
    localparam int COST_BITS = 27;
    localparam int D_BITS    = W_BITS + 1;
    localparam int KEY_BITS  = W_BITS + 2 * CNT_BITS;
    localparam int CFG_BITS  = 7;
    localparam int IDX_BITS  = 1;
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_TDATA_BITS = 32;

    localparam logic [IDX_BITS-1:0] REG_VERTEX_COUNT   = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_SPECIAL_VERTEX = 1'b1;

endpackage

// ===== rtl/second_best_spanning_tree_cost.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// s_axis    | in        | tdata[19:0] edge_weight, tlast last_edge
// m_axis    | out       | tdata[26:0] total_cost, tuser[0] no_alternative
// cfg       | in        | cfg_index 0 vertex_count, 1 special_vertex
//
// Edges load at one transaction per cycle into the edge memory.
// After the last edge, a row-offset sweep runs, then Prim's
// algorithm runs n scans, each followed by a pick step, over one shared
// compare pipeline for n vertices.
// s_axis_tready stays low from the last edge until the result is taken.
// Reset clears all control state; the edge memory holds no reset value.

module second_best_spanning_tree_cost (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sbst_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,  // [19:0] edge_weight
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sbst_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,  // [26:0] total_cost
    output logic [0:0]                          m_axis_tuser,  // [0] no_alternative
    input  logic                                cfg_wr_en,
    input  logic [sbst_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [sbst_pkg::CFG_BITS-1:0]       cfg_data
);
    import sbst_pkg::*;

    typedef enum logic [2:0] {ST_LOAD, ST_BASE, ST_SCAN, ST_PICK, ST_OUT} state_t;

    state_t                state_reg;
    logic [CNT_BITS-1:0]   vc_reg;
    logic [V_BITS-1:0]     sv_reg;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [CNT_BITS-1:0]   bi_reg;
    logic [E_BITS-1:0]     acc_reg;
    logic [CNT_BITS-1:0]   vi_reg;
    logic [V_BITS-1:0]     x_reg;
    logic [V_BITS-1:0]     parx_reg;
    logic [W_BITS-1:0]     wpar_reg;
    logic                  first_reg;
    logic [CNT_BITS-1:0]   tree_n_reg;
    logic [MAX_V-1:0]      in_tree_reg;
    logic [COST_BITS-1:0]  cost_reg;
    logic                  found_reg;
    logic signed [D_BITS-1:0] dmin_reg;
    logic                  mvalid_reg;
    logic [KEY_BITS-1:0]   mkey_reg;
    logic [V_BITS-1:0]     mvert_reg;
    logic [V_BITS-1:0]     mpar_reg;
    logic                  p1_reg, p2_reg;
    logic [V_BITS-1:0]     v1_reg, v2_reg, v3_reg, mn1_reg, mx1_reg, mn2_reg, mx2_reg;
    logic                  c3_reg, k3_reg;
    logic [W_BITS-1:0]     w3_reg, pm3_reg;
    logic [KEY_BITS+V_BITS-1:0] word3_reg;
    logic                  out_valid_reg;
    logic [COST_BITS-1:0]  out_cost_reg;
    logic                  out_flag_reg;

    logic [W_BITS-1:0]          edge_mem [EDGE_CAP];
    logic [E_BITS-1:0]          base_mem [MAX_V];
    logic [KEY_BITS+V_BITS-1:0] best_mem [MAX_V];
    logic [W_BITS-1:0]          pm_mem   [MAX_V*MAX_V];

    logic [E_BITS-1:0]          base_q;
    logic [W_BITS-1:0]          edge_q, pm_q;
    logic [KEY_BITS+V_BITS-1:0] best_q;

    logic [CNT_BITS-1:0]  nv;
    logic                 s_fire, issuing;
    logic [V_BITS-1:0]    vi6, mn0, mx0, pr_lo, pr_hi;
    logic [E_BITS-1:0]    edge_addr;
    logic                 old_tree, sel;
    logic [W_BITS-1:0]    pmnew;
    logic [KEY_BITS-1:0]  newkey;
    logic [KEY_BITS+V_BITS-1:0] word2;
    logic signed [D_BITS-1:0]   d3;
    logic [COST_BITS-1:0] final_cost;

    function automatic logic [CNT_BITS-1:0] rk(input logic [V_BITS-1:0] v,
                                               input logic [V_BITS-1:0] sv);
        rk = (v == sv) ? '0 : ({1'b0, v} + 1'b1);
    endfunction

    assign nv = (vc_reg < CNT_BITS'(2)) ? CNT_BITS'(2) :
                (vc_reg > CNT_BITS'(MAX_V)) ? CNT_BITS'(MAX_V) : vc_reg;
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign issuing = (state_reg == ST_SCAN) && (vi_reg < nv);
    assign vi6 = vi_reg[V_BITS-1:0];
    assign mn0 = (x_reg < vi6) ? x_reg : vi6;
    assign mx0 = (x_reg < vi6) ? vi6 : x_reg;
    assign pr_lo = (parx_reg < v1_reg) ? parx_reg : v1_reg;
    assign pr_hi = (parx_reg < v1_reg) ? v1_reg : parx_reg;
    assign edge_addr = base_q + E_BITS'(mx1_reg - mn1_reg) - E_BITS'(1);

    assign old_tree = in_tree_reg[v2_reg] && (v2_reg != x_reg);
    assign pmnew = (v2_reg == parx_reg) ? wpar_reg :
                   ((pm_q > wpar_reg) ? pm_q : wpar_reg);
    assign newkey = {edge_q, rk(mn2_reg, sv_reg), rk(mx2_reg, sv_reg)};
    assign sel = first_reg || (newkey < best_q[KEY_BITS-1:0]);
    assign word2 = sel ? {x_reg, newkey} : best_q;
    assign d3 = $signed({1'b0, w3_reg}) - $signed({1'b0, pm3_reg});
    assign final_cost = cost_reg + {{(COST_BITS-D_BITS){dmin_reg[D_BITS-1]}}, dmin_reg};

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS-COST_BITS){1'b0}}, out_cost_reg};
    assign m_axis_tuser  = out_flag_reg;

    always_ff @(posedge clk)
    begin
        if (s_fire && (fill_reg < FILL_BITS'(EDGE_CAP)))
        begin
            edge_mem[fill_reg[E_BITS-1:0]] <= s_axis_tdata[W_BITS-1:0];
        end
        edge_q <= edge_mem[edge_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BASE)
        begin
            base_mem[bi_reg[V_BITS-1:0]] <= acc_reg;
        end
        base_q <= base_mem[mn0];
    end

    always_ff @(posedge clk)
    begin
        if (p2_reg && !in_tree_reg[v2_reg])
        begin
            best_mem[v2_reg] <= word2;
        end
        best_q <= best_mem[v1_reg];
    end

    // Path maxima are kept once per vertex pair, lower vertex first.
    always_ff @(posedge clk)
    begin
        if (p2_reg && old_tree)
        begin
            pm_mem[{mn2_reg, mx2_reg}] <= pmnew;
        end
        pm_q <= pm_mem[{pr_lo, pr_hi}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            vc_reg        <= CNT_BITS'(2);
            sv_reg        <= '0;
            fill_reg      <= '0;
            bi_reg        <= '0;
            acc_reg       <= '0;
            vi_reg        <= '0;
            x_reg         <= '0;
            parx_reg      <= '0;
            wpar_reg      <= '0;
            first_reg     <= 1'b0;
            tree_n_reg    <= '0;
            in_tree_reg   <= '0;
            cost_reg      <= '0;
            found_reg     <= 1'b0;
            dmin_reg      <= '0;
            mvalid_reg    <= 1'b0;
            mkey_reg      <= '0;
            mvert_reg     <= '0;
            mpar_reg      <= '0;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            c3_reg        <= 1'b0;
            k3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            out_cost_reg  <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_VERTEX_COUNT:   vc_reg <= cfg_data;
                    REG_SPECIAL_VERTEX: sv_reg <= cfg_data[V_BITS-1:0];
                    default:            vc_reg <= vc_reg;
                endcase
            end

            p1_reg  <= issuing;
            v1_reg  <= vi6;
            mn1_reg <= mn0;
            mx1_reg <= mx0;
            p2_reg  <= p1_reg;
            v2_reg  <= v1_reg;
            mn2_reg <= mn1_reg;
            mx2_reg <= mx1_reg;
            v3_reg  <= v2_reg;
            c3_reg  <= p2_reg && old_tree && (v2_reg != parx_reg);
            k3_reg  <= p2_reg && !in_tree_reg[v2_reg];
            w3_reg  <= edge_q;
            pm3_reg <= pmnew;
            word3_reg <= word2;

            if (c3_reg && (!found_reg || (d3 < dmin_reg)))
            begin
                dmin_reg  <= d3;
                found_reg <= 1'b1;
            end
            if (k3_reg && (!mvalid_reg || (word3_reg[KEY_BITS-1:0] < mkey_reg)))
            begin
                mvalid_reg <= 1'b1;
                mkey_reg   <= word3_reg[KEY_BITS-1:0];
                mvert_reg  <= v3_reg;
                mpar_reg   <= word3_reg[KEY_BITS+V_BITS-1:KEY_BITS];
            end

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (s_fire)
                    begin
                        if (fill_reg < FILL_BITS'(EDGE_CAP))
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            fill_reg  <= '0;
                            bi_reg    <= '0;
                            acc_reg   <= '0;
                            state_reg <= ST_BASE;
                        end
                    end
                end
                ST_BASE:
                begin
                    acc_reg <= acc_reg + E_BITS'(nv - bi_reg - 1'b1);
                    bi_reg  <= bi_reg + 1'b1;
                    if (bi_reg == nv - 1'b1)
                    begin
                        x_reg       <= '0;
                        parx_reg    <= '0;
                        wpar_reg    <= '0;
                        in_tree_reg <= MAX_V'(1);
                        tree_n_reg  <= CNT_BITS'(1);
                        first_reg   <= 1'b1;
                        cost_reg    <= '0;
                        found_reg   <= 1'b0;
                        mvalid_reg  <= 1'b0;
                        vi_reg      <= '0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issuing)
                    begin
                        vi_reg <= vi_reg + 1'b1;
                    end
                    else if (!p1_reg && !p2_reg && !c3_reg && !k3_reg)
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    if (tree_n_reg == nv)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cost_reg  <= found_reg ? final_cost : '0;
                        out_flag_reg  <= !found_reg;
                        state_reg     <= ST_OUT;
                    end
                    else
                    begin
                        x_reg      <= mvert_reg;
                        parx_reg   <= mpar_reg;
                        wpar_reg   <= mkey_reg[KEY_BITS-1:2*CNT_BITS];
                        cost_reg   <= cost_reg + COST_BITS'(mkey_reg[KEY_BITS-1:2*CNT_BITS]);
                        in_tree_reg[mvert_reg] <= 1'b1;
                        tree_n_reg <= tree_n_reg + 1'b1;
                        first_reg  <= 1'b0;
                        mvalid_reg <= 1'b0;
                        vi_reg     <= '0;
                        state_reg  <= ST_SCAN;
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule

// ===== rtl/sbst_checker.sv =====
`timescale 1ns / 1ps

module sbst_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                s_axis_tlast,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [sbst_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input  logic [0:0]                          m_axis_tuser
);
    import sbst_pkg::*;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // No new edge is taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // Loading continues after an edge that is not the last.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=> s_axis_tready)
        else $error("ready dropped during loading");

    // The last edge starts the computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("ready held after last edge");

    // With no alternative edge the cost reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("nonzero cost with no alternative");

endmodule

bind second_best_spanning_tree_cost sbst_checker u_sbst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/tb_second_best_spanning_tree_cost.sv =====
`timescale 1ns / 1ps

module tb_second_best_spanning_tree_cost;
    import sbst_pkg::*;

    localparam int LIMIT = 3000000;
    localparam int DRAIN = 6000;

    typedef enum int {W_RANDOM, W_ZERO, W_MAX, W_TIES} weight_mode_t;

    class cost_scoreboard_t;
        logic [CNT_BITS-1:0] vcount_raw;
        logic [V_BITS-1:0] special;
        int unsigned store [EDGE_CAP];
        int fill;
        logic [COST_BITS:0] expected_q [$];
        int tw [MAX_V][MAX_V];
        int unsigned pm [MAX_V][MAX_V];
        int parent [MAX_V];
        bit in_tree [EDGE_CAP];
        int ea [EDGE_CAP];
        int eb [EDGE_CAP];

        function new();
            vcount_raw = 2;
            special = 0;
            fill = 0;
        endfunction

        function void write_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
            if (idx == REG_VERTEX_COUNT)
                vcount_raw = val;
            else
                special = val[V_BITS-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int root_of(int x);
            while (parent[x] != x)
                x = parent[x];
            return x;
        endfunction

        function int rank_of(int v);
            return (v == special) ? 0 : v + 1;
        endfunction

        function void compute_expected();
            int nv, ne, k, c1, c2, sp, v, u;
            longint keys [$];
            longint tcost, best, d;
            bit found, vis [MAX_V];
            int sv [MAX_V*MAX_V];
            int unsigned sm [MAX_V*MAX_V];
            int unsigned m, mu;
            nv = vcount_raw;
            if (nv < 2) nv = 2;
            if (nv > MAX_V) nv = MAX_V;
            ne = nv * (nv - 1) / 2;
            k = 0;
            for (int i = 0; i + 1 < nv; i++)
                for (int j = i + 1; j < nv; j++)
                begin
                    ea[k] = i;
                    eb[k] = j;
                    keys.push_back((longint'(store[k]) << 25) | (longint'(rank_of(i)) << 18)
                                   | (longint'(rank_of(j)) << 11) | longint'(k));
                    k++;
                end
            keys.sort();
            for (int i = 0; i < MAX_V; i++)
            begin
                parent[i] = i;
                for (int j = 0; j < MAX_V; j++)
                begin
                    tw[i][j] = -1;
                    pm[i][j] = 0;
                end
            end
            for (int i = 0; i < ne; i++)
                in_tree[i] = 0;
            tcost = 0;
            foreach (keys[q])
            begin
                k = int'(keys[q] & 11'h7ff);
                c1 = root_of(ea[k]);
                c2 = root_of(eb[k]);
                if (c1 != c2)
                begin
                    parent[c1] = c2;
                    tcost += store[k];
                    tw[ea[k]][eb[k]] = int'(store[k]);
                    tw[eb[k]][ea[k]] = int'(store[k]);
                    in_tree[k] = 1;
                end
            end
            for (int r = 0; r < nv; r++)
            begin
                for (int i = 0; i < MAX_V; i++)
                    vis[i] = 0;
                vis[r] = 1;
                sv[0] = r;
                sm[0] = 0;
                sp = 1;
                while (sp > 0)
                begin
                    sp--;
                    v = sv[sp];
                    m = sm[sp];
                    for (u = 0; u < nv; u++)
                        if (tw[v][u] >= 0 && !vis[u])
                        begin
                            vis[u] = 1;
                            mu = (int'(m) > tw[v][u]) ? m : tw[v][u];
                            pm[r][u] = mu;
                            sv[sp] = u;
                            sm[sp] = mu;
                            sp++;
                        end
                end
            end
            found = 0;
            best = 0;
            for (int i = 0; i < ne; i++)
                if (!in_tree[i])
                begin
                    d = longint'(store[i]) - longint'(pm[ea[i]][eb[i]]);
                    if (!found || d < best) best = d;
                    found = 1;
                end
            if (found)
                expected_q.push_back({1'b0, COST_BITS'(tcost + best)});
            else
                expected_q.push_back({1'b1, {COST_BITS{1'b0}}});
        endfunction

        function void note_edge(logic [W_BITS-1:0] w, logic last);
            if (fill < EDGE_CAP)
            begin
                store[fill] = w;
                fill++;
            end
            if (last)
            begin
                compute_expected();
                fill = 0;
            end
        endfunction

        function bit check_result(logic [COST_BITS-1:0] cost, logic flag, output string msg);
            logic [COST_BITS:0] e;
            if (expected_q.size() == 0)
            begin
                msg = $sformatf("result with no expectation: cost %0d flag %0d", cost, flag);
                return 0;
            end
            e = expected_q.pop_front();
            if (e[COST_BITS] !== flag)
            begin
                msg = $sformatf("no_alternative got %0d expected %0d", flag, e[COST_BITS]);
                return 0;
            end
            if (e[COST_BITS-1:0] !== cost)
            begin
                msg = $sformatf("total_cost got %0d expected %0d", cost, e[COST_BITS-1:0]);
                return 0;
            end
            return 1;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_TDATA_BITS-1:0] s_axis_tdata;
    logic s_axis_tlast;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic cfg_wr_en;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    cost_scoreboard_t sb;
    int errors = 0;
    int cycles = 0;
    int items = 0;
    int hw_mark = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int recv_hold = 0;

    second_best_spanning_tree_cost u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic report(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("second_best_spanning_tree_cost regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (!sb.check_result(m_axis_tdata[COST_BITS-1:0], m_axis_tuser[0], msg))
                report(msg);
        end
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [W_BITS-1:0] pick_weight(weight_mode_t mode);
        unique case (mode)
            W_ZERO: return '0;
            W_MAX: return '1;
            W_TIES: return W_BITS'($urandom_range(3));
            default: return W_BITS'($urandom);
        endcase
    endfunction

    task automatic send_edge(input logic [W_BITS-1:0] w, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_BITS-W_BITS){1'b0}}, w};
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_edge(w, last);
        items++;
    endtask

    // count = 0 sends exactly one full graph for the chosen vertex count.
    task automatic run_graph(input int n_raw, input int spv, input int count,
                             input weight_mode_t mode, input bit configure);
        int nv, ne;
        if (configure)
        begin
            wait_idle();
            write_reg(REG_VERTEX_COUNT, CFG_BITS'(n_raw));
            write_reg(REG_SPECIAL_VERTEX, CFG_BITS'(spv));
            cfg_wr_en <= 1'b0;
        end
        nv = (n_raw < 2) ? 2 : (n_raw > MAX_V) ? MAX_V : n_raw;
        ne = nv * (nv - 1) / 2;
        if (count == 0 || (count < ne && hw_mark < ne))
            count = ne;
        if (count > hw_mark)
            hw_mark = (count > EDGE_CAP) ? EDGE_CAP : count;
        for (int i = 0; i < count; i++)
            send_edge(pick_weight(mode), i == count - 1);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
    endtask

    initial
    begin
        int n, ne, cnt, r;
        sb = new();
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_VERTEX_COUNT;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_graph(2, 0, 0, W_ZERO, 1);
        run_graph(30, 5, 0, W_RANDOM, 1);
        run_graph(3, 2, 0, W_MAX, 1);
        run_graph(4, 3, 0, W_ZERO, 1);
        run_graph(0, 0, 0, W_RANDOM, 1);
        run_graph(1, 1, 0, W_TIES, 1);
        run_graph(5, 40, 0, W_TIES, 1);
        run_graph(10, 9, 20, W_RANDOM, 1);
        run_graph(6, 0, 0, W_MAX, 1);

        wait_idle();
        recv_hold = 3000;
        run_graph(6, 1, 0, W_RANDOM, 0);
        @(posedge clk);
        run_graph(6, 1, 0, W_TIES, 0);

        while (items < 1200)
        begin
            if (items < 750)
            begin
                send_idle = 9;
                recv_idle = 78;
            end
            else if (items < 980)
            begin
                send_idle = 78;
                recv_idle = 9;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            r = $urandom_range(99);
            if (r < 5)
                n = $urandom_range(13, 20);
            else if (r < 10)
                n = $urandom_range(1);
            else
                n = $urandom_range(2, 12);
            ne = (n < 2) ? 1 : n * (n - 1) / 2;
            r = $urandom_range(9);
            if (r == 0 && ne > 1)
                cnt = $urandom_range(1, ne - 1);
            else if (r == 1)
                cnt = ne + $urandom_range(1, 5);
            else
                cnt = 0;
            run_graph(n, $urandom_range(63), cnt, weight_mode_t'($urandom_range(3)), 1);
        end

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0 && sb.pending() == 0)
            $display("second_best_spanning_tree_cost regression: pass");
        else
            $display("second_best_spanning_tree_cost regression: fail");
        $finish;
    end

endmodule
